[rtl/mrpt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_pkg
// Shared types and constants for the Miller-Rabin primality test unit.
// ----------------------------------------------------------------------------
package mrpt_pkg;

    localparam int NUM_SMALL = 12;
    localparam int NUM_BASES = 7;

    typedef logic [5:0]  small_prime_t;
    typedef logic [30:0] mr_base_t;

    function automatic small_prime_t small_prime(input logic [3:0] idx);
        small_prime_t p;
        begin
            unique case (idx)
                4'd0:    p = 6'd2;
                4'd1:    p = 6'd3;
                4'd2:    p = 6'd5;
                4'd3:    p = 6'd7;
                4'd4:    p = 6'd11;
                4'd5:    p = 6'd13;
                4'd6:    p = 6'd17;
                4'd7:    p = 6'd19;
                4'd8:    p = 6'd23;
                4'd9:    p = 6'd29;
                4'd10:   p = 6'd31;
                4'd11:   p = 6'd37;
                default: p = 6'd37;
            endcase
            return p;
        end
    endfunction

    function automatic mr_base_t mr_base(input logic [2:0] idx);
        mr_base_t b;
        begin
            unique case (idx)
                3'd0:    b = 31'd2;
                3'd1:    b = 31'd325;
                3'd2:    b = 31'd9375;
                3'd3:    b = 31'd28178;
                3'd4:    b = 31'd450775;
                3'd5:    b = 31'd9780504;
                3'd6:    b = 31'd1795265022;
                default: b = 31'd2;
            endcase
            return b;
        end
    endfunction

    // shared modular unit operations
    typedef enum logic [1:0] {
        OP_MUL = 2'd0,   // a * b mod n, one bit per cycle
        OP_REM = 2'd1    // a mod n, restoring, one bit per cycle
    } mod_op_t;

    typedef struct packed {
        logic    start;
        mod_op_t op;
    } mod_ctrl_t;

endpackage

[rtl/mrpt_mod_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_mod_unit
// Bit-serial modular multiply and modular reduction, one bit per cycle.
// ----------------------------------------------------------------------------
module mrpt_mod_unit #(
    parameter int WORD_BITS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mrpt_pkg::mod_ctrl_t  ctrl,
    input  logic [WORD_BITS-1:0] opa,
    input  logic [WORD_BITS-1:0] opb,
    input  logic [WORD_BITS-1:0] modulus,
    output logic                 done,
    output logic [WORD_BITS-1:0] result
);

    localparam int CW = $clog2(WORD_BITS);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    mrpt_pkg::mod_op_t    op_reg, op_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] a_reg, a_next;
    logic [WORD_BITS-1:0] b_reg, b_next;

    logic [WORD_BITS-1:0] room_acc, dbl, room_a, dbl_add;
    logic [WORD_BITS:0]   rem_sh;
    logic [WORD_BITS-1:0] rem_new;

    always_comb begin
        // acc + acc mod n
        room_acc = modulus - acc_reg;
        dbl      = (acc_reg >= room_acc) ? (acc_reg - room_acc) : (acc_reg + acc_reg);
        room_a   = modulus - a_reg;
        dbl_add  = (dbl >= room_a) ? (dbl - room_a) : (dbl + a_reg);
        // restoring remainder step
        rem_sh   = {acc_reg, b_reg[WORD_BITS-1]};
        rem_new  = (rem_sh >= {1'b0, modulus}) ? WORD_BITS'(rem_sh - {1'b0, modulus})
                                               : rem_sh[WORD_BITS-1:0];
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (ctrl.start) begin
            busy_next = 1'b1;
            op_next   = ctrl.op;
            cnt_next  = CW'(WORD_BITS - 1);
            acc_next  = '0;
            a_next    = opa;
            b_next    = (ctrl.op == mrpt_pkg::OP_MUL) ? opb : opa;
        end else if (busy_reg) begin
            unique case (op_reg)
                mrpt_pkg::OP_MUL: acc_next = b_reg[WORD_BITS-1] ? dbl_add : dbl;
                mrpt_pkg::OP_REM: acc_next = rem_new;
                default:          acc_next = acc_reg;
            endcase
            b_next   = {b_reg[WORD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= mrpt_pkg::OP_MUL;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

[rtl/mrpt_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_seq
// Sequencer: trial division, d*2^s split, and Miller-Rabin rounds.
// ----------------------------------------------------------------------------
module mrpt_seq #(
    parameter int WORD_BITS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] n_in,
    output logic                 idle,
    output logic                 fin,
    output logic                 verdict,
    output mrpt_pkg::mod_ctrl_t  ctrl,
    output logic [WORD_BITS-1:0] opa,
    output logic [WORD_BITS-1:0] opb,
    output logic [WORD_BITS-1:0] modulus,
    input  logic                 mu_done,
    input  logic [WORD_BITS-1:0] mu_result
);

    localparam int CW = $clog2(WORD_BITS) + 1;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_TRIAL  = 11'b00000000010,
        S_TWAIT  = 11'b00000000100,
        S_SPLIT  = 11'b00000001000,
        S_BASE   = 11'b00000010000,
        S_BWAIT  = 11'b00000100000,
        S_POW    = 11'b00001000000,
        S_PWAIT  = 11'b00010000000,
        S_CHECK  = 11'b00100000000,
        S_SQWAIT = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } state_t;

    state_t               state_reg, state_next;
    logic [WORD_BITS-1:0] n_reg, n_next;
    logic [WORD_BITS-1:0] d_reg, d_next;
    logic [CW-1:0]        s_reg, s_next;
    logic [CW-1:0]        r_reg, r_next;
    logic [WORD_BITS-1:0] e_reg, e_next;
    logic [WORD_BITS-1:0] x_reg, x_next;
    logic [WORD_BITS-1:0] bs_reg, bs_next;
    logic [3:0]           k_reg, k_next;
    logic                 sqr_reg, sqr_next;
    logic                 res_reg, res_next;
    mrpt_pkg::mod_ctrl_t  ctrl_c;
    logic [WORD_BITS-1:0] opa_c, opb_c;
    logic [WORD_BITS-1:0] nm1;
    logic [WORD_BITS-1:0] sp_w;

    assign nm1  = n_reg - 1'b1;
    assign sp_w = WORD_BITS'(mrpt_pkg::small_prime(k_reg));

    always_comb begin
        state_next = state_reg;
        n_next = n_reg; d_next = d_reg; s_next = s_reg; r_next = r_reg;
        e_next = e_reg; x_next = x_reg; bs_next = bs_reg; k_next = k_reg;
        sqr_next = sqr_reg; res_next = res_reg;
        ctrl_c = '{start: 1'b0, op: mrpt_pkg::OP_MUL};
        opa_c  = x_reg;
        opb_c  = bs_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    n_next = n_in;
                    k_next = '0;
                    if (n_in < WORD_BITS'(2)) begin
                        res_next   = 1'b0;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_TRIAL;
                    end
                end
            end
            // n mod small prime computed as n mod p via the unit with modulus p
            S_TRIAL: begin
                ctrl_c     = '{start: 1'b1, op: mrpt_pkg::OP_REM};
                opa_c      = n_reg;
                state_next = S_TWAIT;
            end
            S_TWAIT: begin
                if (mu_done) begin
                    if (mu_result == '0) begin
                        res_next   = (n_reg == sp_w);
                        state_next = S_DONE;
                    end else if (k_reg == 4'(mrpt_pkg::NUM_SMALL - 1)) begin
                        d_next     = nm1;
                        s_next     = '0;
                        state_next = S_SPLIT;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_TRIAL;
                    end
                end
            end
            S_SPLIT: begin
                if (d_reg[0]) begin
                    k_next     = '0;
                    state_next = S_BASE;
                end else begin
                    d_next = d_reg >> 1;
                    s_next = s_reg + 1'b1;
                end
            end
            S_BASE: begin
                if (k_reg == 4'(mrpt_pkg::NUM_BASES)) begin
                    res_next   = 1'b1;
                    state_next = S_DONE;
                end else begin
                    ctrl_c     = '{start: 1'b1, op: mrpt_pkg::OP_REM};
                    opa_c      = WORD_BITS'(mrpt_pkg::mr_base(k_reg[2:0]));
                    state_next = S_BWAIT;
                end
            end
            S_BWAIT: begin
                if (mu_done) begin
                    if (mu_result == '0) begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_BASE;
                    end else begin
                        bs_next    = mu_result;
                        x_next     = WORD_BITS'(1);
                        e_next     = d_reg;
                        state_next = S_POW;
                    end
                end
            end
            // square-and-multiply, multiply step (when the exponent bit is set) then square step per exponent bit
            S_POW: begin
                if (e_reg == '0) begin
                    r_next     = CW'(1);
                    state_next = S_CHECK;
                    if (x_reg == WORD_BITS'(1) || x_reg == nm1) begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_BASE;
                    end
                end else begin
                    ctrl_c     = '{start: 1'b1, op: mrpt_pkg::OP_MUL};
                    sqr_next   = ~e_reg[0];
                    opa_c      = e_reg[0] ? x_reg : bs_reg;
                    opb_c      = bs_reg;
                    state_next = S_PWAIT;
                end
            end
            S_PWAIT: begin
                if (mu_done) begin
                    if (!sqr_reg) begin
                        x_next     = mu_result;
                        sqr_next   = 1'b1;
                        ctrl_c     = '{start: 1'b1, op: mrpt_pkg::OP_MUL};
                        opa_c      = bs_reg;
                        opb_c      = bs_reg;
                    end else begin
                        bs_next    = mu_result;
                        e_next     = e_reg >> 1;
                        state_next = S_POW;
                    end
                end
            end
            S_CHECK: begin
                if (r_reg >= s_reg) begin
                    res_next   = 1'b0;
                    state_next = S_DONE;
                end else begin
                    ctrl_c     = '{start: 1'b1, op: mrpt_pkg::OP_MUL};
                    opa_c      = x_reg;
                    opb_c      = x_reg;
                    state_next = S_SQWAIT;
                end
            end
            S_SQWAIT: begin
                if (mu_done) begin
                    x_next = mu_result;
                    r_next = r_reg + 1'b1;
                    if (mu_result == nm1) begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_BASE;
                    end else begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_DONE: begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        n_reg <= n_next; d_reg <= d_next; s_reg <= s_next; r_reg <= r_next;
        e_reg <= e_next; x_reg <= x_next; bs_reg <= bs_next; k_reg <= k_next;
        sqr_reg <= sqr_next; res_reg <= res_next;
    end

    assign idle    = (state_reg == S_IDLE);
    assign fin     = (state_reg == S_DONE);
    assign verdict = res_reg;
    assign ctrl    = ctrl_c;
    assign opa     = opa_c;
    assign opb     = opb_c;
    // trial division reduces modulo the small prime while it runs, all else modulo n
    assign modulus = (state_reg == S_TRIAL || state_reg == S_TWAIT) ? sp_w : n_reg;

endmodule

[rtl/miller_rabin_prime_test_64_unit.sv]
`timescale 1ns / 1ps
// sequence: trial division by up to twelve small primes, then per base one reduction
//   and up to 2*WORD_BITS modular multiplies
// transactions: one at a time, the next is accepted once the result is taken
// reset: synchronous active-low aresetn returns the sequencer to idle
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_64_unit
// Deterministic 64-bit Miller-Rabin primality test on one shared modular unit.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_64_unit #(
    parameter int WORD_BITS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_candidate,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_prime_flag
);

    mrpt_pkg::mod_ctrl_t  ctrl;
    logic [WORD_BITS-1:0] opa, opb, modulus, mu_result;
    logic                 mu_done, idle, fin, verdict;
    logic                 busy_reg, busy_next;
    logic                 mval_reg, mval_next;
    logic                 flag_reg, flag_next;

    mrpt_seq #(.WORD_BITS(WORD_BITS)) u_seq (
        .aclk(aclk), .aresetn(aresetn),
        .start(s_valid && s_ready),
        .n_in(s_candidate[WORD_BITS-1:0]),
        .idle(idle), .fin(fin), .verdict(verdict),
        .ctrl(ctrl), .opa(opa), .opb(opb), .modulus(modulus),
        .mu_done(mu_done), .mu_result(mu_result)
    );

    mrpt_mod_unit #(.WORD_BITS(WORD_BITS)) u_mod (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl),
        .opa(opa), .opb(opb), .modulus(modulus),
        .done(mu_done), .result(mu_result)
    );

    // busy covers time from accept until the result is taken at the output
    assign s_ready = idle && !busy_reg;

    always_comb begin
        busy_next = busy_reg;
        mval_next = mval_reg;
        flag_next = flag_reg;
        if (s_valid && s_ready) busy_next = 1'b1;
        if (m_valid && m_ready) mval_next = 1'b0;
        if (fin) begin
            mval_next = 1'b1;
            flag_next = verdict;
        end
        if (m_valid && m_ready) busy_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            mval_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            mval_reg <= mval_next;
        end
        flag_reg <= flag_next;
    end

    assign m_valid      = mval_reg;
    assign m_prime_flag = flag_reg;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input accepted while result pending");
    a_fin_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        fin |=> m_valid) else $error("finished result not presented");
    a_mod_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !ctrl.start) else $error("modular unit started while idle");
`endif

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 64-bit Miller-Rabin primality test unit. Sends
// directed and random candidates under random idling on both channels and
// compares every prime flag with an independent in-bench primality check.
// ----------------------------------------------------------------------------
module tb;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_candidate;
    logic        m_valid;
    logic        m_ready;
    logic        m_prime_flag;

    logic        flag_queue[$];
    int          errors;
    bit          quiet;
    int          hold_cycles;
    int          stall_left;

    miller_rabin_prime_test_64_unit i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_candidate  (s_candidate),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_prime_flag (m_prime_flag)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] n);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return 64'(prod % {64'd0, n});
    endfunction

    function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e, logic [63:0] n);
        logic [63:0] acc;
        acc = 64'd1;
        while (e != 0) begin
            if (e[0]) acc = mulmod(acc, b, n);
            b = mulmod(b, b, n);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic logic prime_ref(logic [63:0] n);
        logic [63:0] trial[12];
        logic [63:0] witness[7];
        logic [63:0] d;
        logic [63:0] a;
        logic [63:0] x;
        int          s;
        bit          comp;
        trial   = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
        witness = '{2, 325, 9375, 28178, 450775, 9780504, 1795265022};
        if (n < 2) return 1'b0;
        foreach (trial[k]) begin
            if (n % trial[k] == 0) return n == trial[k];
        end
        d = n - 1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        foreach (witness[k]) begin
            a = witness[k] % n;
            if (a == 0) continue;
            x = powmod(a, d, n);
            if (x == 1 || x == n - 1) continue;
            comp = 1'b1;
            for (int r = 1; r < s; r++) begin
                x = mulmod(x, x, n);
                if (x == n - 1) begin
                    comp = 1'b0;
                    break;
                end
            end
            if (comp) return 1'b0;
        end
        return 1'b1;
    endfunction

    // expected flags are queued when the input transaction is accepted
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) flag_queue.push_back(prime_ref(s_candidate));
        if (aresetn && m_valid && m_ready) begin
            if (flag_queue.size() == 0) begin
                $error("unexpected result transaction, prime_flag=%0b", m_prime_flag);
                errors++;
            end else begin
                logic want;
                want = flag_queue.pop_front();
                if (want !== m_prime_flag) begin
                    $error("prime_flag mismatch: expected %0b actual %0b", want, m_prime_flag);
                    errors++;
                end
            end
        end
    end

    // receiver: random stall bursts plus a long hold-off set by the backpressure test
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 8) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_candidate(input logic [63:0] value);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_candidate <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic go_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (flag_queue.size() != 0) @(posedge aclk);
    endtask

    task automatic test_edges();
        send_candidate(64'd0);
        send_candidate(64'd1);
        send_candidate(64'd2);
        send_candidate(64'd4);
        send_candidate(64'd37);
        send_candidate(64'd41);
        send_candidate(64'hFFFF_FFFF_FFFF_FFFF);
        send_candidate(64'hFFFF_FFFF_FFFF_FFC5);  // largest 64-bit prime
        send_candidate(64'h1FFF_FFFF_FFFF_FFFF);  // mersenne prime 2^61-1
        send_candidate(64'h8000_0000_0000_0000);
    endtask

    // candidates that divide a witness, so that round is skipped
    task automatic test_skipped_witness();
        send_candidate(64'd73);
        send_candidate(64'd193);
        send_candidate(64'd14089);
    endtask

    task automatic test_pseudoprimes();
        send_candidate(64'd561);
        send_candidate(64'd2047);
        send_candidate(64'd3215031751);
        send_candidate(64'd3825123056546413051);
        send_candidate(64'd4294967291);
        send_candidate(64'd4294967297);
    endtask

    // long receiver hold-off, longer than the slowest transaction
    task automatic test_backpressure();
        hold_cycles = 80000;
        repeat (4) send_candidate({$urandom, $urandom} | 64'd1);
    endtask

    // sender stops until every expected flag is back
    task automatic test_drain_pause();
        go_idle();
        wait_drained();
        send_candidate(64'd1000000007);
        send_candidate(64'd999999999989);
    endtask

    task automatic test_random(input int count);
        logic [63:0] v;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 3))
                0: v = {$urandom, $urandom};
                1: v = {$urandom, $urandom} | 64'd1;
                2: v = 64'($urandom_range(0, 5000));
                default: v = {$urandom, $urandom} | 64'h8000_0000_0000_0001;
            endcase
            send_candidate(v);
        end
    endtask

    initial begin
        errors      = 0;
        quiet       = 1'b0;
        hold_cycles = 0;
        stall_left  = 0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_candidate = 64'd0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_edges();
        test_skipped_witness();
        test_pseudoprimes();
        test_backpressure();
        test_drain_pause();
        test_random(100);
        quiet = 1'b1;
        test_random(15);
        go_idle();
        wait_drained();
        repeat (200) @(posedge aclk);
        if (flag_queue.size() != 0) begin
            $error("%0d expected results never arrived", flag_queue.size());
            errors++;
        end
        if (errors == 0) begin
            $display("[miller_rabin_prime_test_64_unit] OK");
        end else begin
            $display("[miller_rabin_prime_test_64_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #400ms;
        $display("[miller_rabin_prime_test_64_unit] ERROR");
        $finish;
    end

endmodule
